// ----- rtl/vpd_pkg.sv -----
`timescale 1ns / 1ps
package vpd_pkg;

   localparam int unsigned VPD_MAX_IMAGE_BYTES = 32768;
   localparam int unsigned VPD_MAX_RESULTS     = 3;

   // input opcodes
   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_FIELD  = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   // field ids
   localparam logic [1:0] FID_NAME = 2'd0;
   localparam logic [1:0] FID_PN   = 2'd1;
   localparam logic [1:0] FID_SN   = 2'd2;

   // finish reasons
   localparam logic [1:0] FIN_END_TAG    = 2'd0;
   localparam logic [1:0] FIN_CONSUMED   = 2'd1;
   localparam logic [1:0] FIN_SHORT_HDR  = 2'd2;
   localparam logic [1:0] FIN_PAST_IMAGE = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  field_id;
      logic [7:0]  value_byte;
      logic [15:0] trimmed_length;
      logic [1:0]  finish_status;
      logic        last;
   } rsp_item_type;

   // everything one input item produces
   typedef struct packed {
      logic [1:0]                             count;
      rsp_item_type [VPD_MAX_RESULTS-1:0]     item;
   } step_out_type;

   function automatic rsp_item_type make_item(input logic [1:0]  kind,
                                              input logic [1:0]  fid,
                                              input logic [7:0]  vb,
                                              input logic [15:0] tl,
                                              input logic [1:0]  fs);
      rsp_item_type r;
      r.kind           = kind;
      r.field_id       = fid;
      r.value_byte     = vb;
      r.trimmed_length = tl;
      r.finish_status  = fs;
      r.last           = 1'b0;
      return r;
   endfunction

endpackage

// ----- rtl/vpd_parse.sv -----
`timescale 1ns / 1ps
module vpd_parse
   import vpd_pkg::*;
#(
   parameter int unsigned MAX_IMAGE_BYTES = VPD_MAX_IMAGE_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_valid,
   input  logic         opcode,
   input  logic [15:0]  image_length,
   input  logic [7:0]   data_byte,
   output step_out_type step_out
);

   localparam logic [16:0] MaxLen     = 17'(MAX_IMAGE_BYTES);
   localparam logic [6:0]  TagIdent   = 7'h02;
   localparam logic [6:0]  TagVpdr    = 7'h10;
   localparam logic [3:0]  SmallEnd   = 4'hf;
   localparam logic [7:0]  CharP      = 8'h50;
   localparam logic [7:0]  CharN      = 8'h4e;
   localparam logic [7:0]  CharS      = 8'h53;
   localparam logic [7:0]  CharSpace  = 8'h20;

   typedef enum logic [3:0] {
      PH_IDLE, PH_TAG, PH_LEN_LO, PH_LEN_HI, PH_IDENT, PH_K0, PH_K1,
      PH_KLEN, PH_KDATA, PH_SKIP, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {RK_OTHER, RK_IDENT, RK_VPDR} rkind_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] consumed_ff, consumed_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  len_low_ff, len_low_in;
   logic [15:0] res_rem_ff, res_rem_in;
   rkind_type   res_kind_ff, res_kind_in;
   logic [7:0]  kw_first_ff, kw_first_in;
   logic [1:0]  kw_class_ff, kw_class_in;
   logic [7:0]  kw_rem_ff, kw_rem_in;
   logic [15:0] fcount_ff, fcount_in;
   logic [15:0] kept_ff, kept_in;

   // at a keyword boundary inside VPD-R
   function automatic phase_type next_keyword(input logic [15:0] rem);
      phase_type p;
      if (rem == 16'd0) p = PH_TAG;
      else if (rem < 16'd3) p = PH_SKIP;
      else p = PH_K0;
      return p;
   endfunction

   always_comb begin
      logic [1:0]   n;
      rsp_item_type [VPD_MAX_RESULTS-1:0] items;
      logic [7:0]   b;
      logic [15:0]  len;
      logic [16:0]  len17;

      phase_in    = phase_ff;
      consumed_in = consumed_ff;
      total_in    = total_ff;
      len_low_in  = len_low_ff;
      res_rem_in  = res_rem_ff;
      res_kind_in = res_kind_ff;
      kw_first_in = kw_first_ff;
      kw_class_in = kw_class_ff;
      kw_rem_in   = kw_rem_ff;
      fcount_in   = fcount_ff;
      kept_in     = kept_ff;
      n           = 2'd0;
      items       = '0;
      b           = data_byte;
      len         = {b, len_low_ff};
      len17       = {1'b0, image_length};

      if (step_valid && opcode == OP_BEGIN) begin
         // fresh image: per-image state back to zero and the clamped length loaded
         consumed_in = '0;
         len_low_in  = '0;
         res_rem_in  = '0;
         res_kind_in = RK_OTHER;
         kw_first_in = '0;
         kw_class_in = '0;
         kw_rem_in   = '0;
         fcount_in   = '0;
         kept_in     = '0;
         total_in    = (len17 > MaxLen) ? MaxLen[15:0] : image_length;
         phase_in    = PH_TAG;
         if (total_in == 16'd0) begin
            items[n] = make_item(KIND_FINISH, FID_NAME, 8'd0, 16'd0, FIN_CONSUMED);
            n        = n + 2'd1;
            phase_in = PH_DONE;
         end
      end else if (step_valid && phase_ff != PH_IDLE && phase_ff != PH_DONE) begin
         consumed_in = consumed_ff + 16'd1;
         unique case (phase_ff)
            PH_TAG: begin
               if (b[7]) begin
                  if ({1'b0, consumed_ff} + 17'd3 > {1'b0, total_ff}) begin
                     items[n] = make_item(KIND_FINISH, FID_NAME, 8'd0, 16'd0,
                                          FIN_SHORT_HDR);
                     n        = n + 2'd1;
                     phase_in = PH_DONE;
                  end else begin
                     res_kind_in = (b[6:0] == TagIdent) ? RK_IDENT :
                                   (b[6:0] == TagVpdr)  ? RK_VPDR : RK_OTHER;
                     phase_in    = PH_LEN_LO;
                  end
               end else if (b[6:3] == SmallEnd) begin
                  items[n] = make_item(KIND_FINISH, FID_NAME, 8'd0, 16'd0, FIN_END_TAG);
                  n        = n + 2'd1;
                  phase_in = PH_DONE;
               end else begin
                  res_rem_in = {13'd0, b[2:0]};
                  phase_in   = (b[2:0] != 3'd0) ? PH_SKIP : PH_TAG;
               end
            end
            PH_LEN_LO: begin
               len_low_in = b;
               phase_in   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               if ({1'b0, consumed_in} + {1'b0, len} > {1'b0, total_ff}) begin
                  items[n] = make_item(KIND_FINISH, FID_NAME, 8'd0, 16'd0,
                                       FIN_PAST_IMAGE);
                  n        = n + 2'd1;
                  phase_in = PH_DONE;
               end else begin
                  res_rem_in = len;
                  unique case (res_kind_ff)
                     RK_IDENT: begin
                        fcount_in = '0;
                        kept_in   = '0;
                        if (len == 16'd0) begin
                           items[n] = make_item(KIND_FIELD, FID_NAME, 8'd0, 16'd0,
                                                FIN_END_TAG);
                           n        = n + 2'd1;
                           phase_in = PH_TAG;
                        end else begin
                           phase_in = PH_IDENT;
                        end
                     end
                     RK_VPDR:  phase_in = next_keyword(len);
                     default:  phase_in = (len != 16'd0) ? PH_SKIP : PH_TAG;
                  endcase
               end
            end
            PH_IDENT: begin
               items[n]  = make_item(KIND_BYTE, FID_NAME, b, 16'd0, FIN_END_TAG);
               n         = n + 2'd1;
               fcount_in = fcount_ff + 16'd1;
               if (b != CharSpace && b != 8'd0) kept_in = fcount_in;
               res_rem_in = res_rem_ff - 16'd1;
               if (res_rem_in == 16'd0) begin
                  items[n] = make_item(KIND_FIELD, FID_NAME, 8'd0, kept_in, FIN_END_TAG);
                  n        = n + 2'd1;
                  phase_in = PH_TAG;
               end
            end
            PH_K0: begin
               kw_first_in = b;
               res_rem_in  = res_rem_ff - 16'd1;
               phase_in    = PH_K1;
            end
            PH_K1: begin
               if (kw_first_ff == CharP && b == CharN) kw_class_in = FID_PN;
               else if (kw_first_ff == CharS && b == CharN) kw_class_in = FID_SN;
               else kw_class_in = FID_NAME;   // not of interest
               res_rem_in = res_rem_ff - 16'd1;
               phase_in   = PH_KLEN;
            end
            PH_KLEN: begin
               res_rem_in = res_rem_ff - 16'd1;
               if ({8'd0, b} > res_rem_in) begin
                  // truncated keyword: drop the rest of the block
                  phase_in = (res_rem_in != 16'd0) ? PH_SKIP : PH_TAG;
               end else begin
                  kw_rem_in = b;
                  fcount_in = '0;
                  kept_in   = '0;
                  if (b == 8'd0) begin
                     if (kw_class_ff != FID_NAME) begin
                        items[n] = make_item(KIND_FIELD, kw_class_ff, 8'd0, 16'd0,
                                             FIN_END_TAG);
                        n        = n + 2'd1;
                     end
                     phase_in = next_keyword(res_rem_in);
                  end else begin
                     phase_in = PH_KDATA;
                  end
               end
            end
            PH_KDATA: begin
               res_rem_in = res_rem_ff - 16'd1;
               kw_rem_in  = kw_rem_ff - 8'd1;
               if (kw_class_ff != FID_NAME) begin
                  items[n]  = make_item(KIND_BYTE, kw_class_ff, b, 16'd0, FIN_END_TAG);
                  n         = n + 2'd1;
                  fcount_in = fcount_ff + 16'd1;
                  if (b != CharSpace && b != 8'd0) kept_in = fcount_in;
               end
               if (kw_rem_in == 8'd0) begin
                  if (kw_class_ff != FID_NAME) begin
                     items[n] = make_item(KIND_FIELD, kw_class_ff, 8'd0, kept_in,
                                          FIN_END_TAG);
                     n        = n + 2'd1;
                  end
                  phase_in = next_keyword(res_rem_in);
               end
            end
            default: begin   // PH_SKIP
               if (res_rem_ff != 16'd0) res_rem_in = res_rem_ff - 16'd1;
               if (res_rem_in == 16'd0) phase_in = PH_TAG;
            end
         endcase

         if (phase_in != PH_DONE && consumed_in >= total_ff) begin
            items[n] = make_item(KIND_FINISH, FID_NAME, 8'd0, 16'd0, FIN_CONSUMED);
            n        = n + 2'd1;
            phase_in = PH_DONE;
         end
      end

      unique case (n)
         2'd1:    items[0].last = 1'b1;
         2'd2:    items[1].last = 1'b1;
         2'd3:    items[2].last = 1'b1;
         default: ;
      endcase

      step_out.count = n;
      step_out.item  = items;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         consumed_ff <= '0;
         total_ff    <= '0;
         len_low_ff  <= '0;
         res_rem_ff  <= '0;
         res_kind_ff <= RK_OTHER;
         kw_first_ff <= '0;
         kw_class_ff <= '0;
         kw_rem_ff   <= '0;
         fcount_ff   <= '0;
         kept_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         consumed_ff <= consumed_in;
         total_ff    <= total_in;
         len_low_ff  <= len_low_in;
         res_rem_ff  <= res_rem_in;
         res_kind_ff <= res_kind_in;
         kw_first_ff <= kw_first_in;
         kw_class_ff <= kw_class_in;
         kw_rem_ff   <= kw_rem_in;
         fcount_ff   <= fcount_in;
         kept_ff     <= kept_in;
      end
   end

endmodule

// ----- rtl/vpd_rbuf.sv -----
`timescale 1ns / 1ps
module vpd_rbuf
   import vpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  step_out_type load_data,
   output logic         can_load,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   // slot 0 is the head; results shift down as they leave
   logic [1:0]   count_ff, count_in;
   rsp_item_type [VPD_MAX_RESULTS-1:0] slot_ff, slot_in;
   logic pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[0];
   assign pop       = out_valid & out_ready;
   assign can_load  = (count_ff == 2'd0) | ((count_ff == 2'd1) & pop);

   always_comb begin
      count_in = count_ff;
      slot_in  = slot_ff;
      if (load) begin
         count_in = load_data.count;
         slot_in  = load_data.item;
      end else if (pop) begin
         count_in   = count_ff - 2'd1;
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff <= slot_in;
   end

endmodule

// ----- rtl/pci_vpd_field_extractor.sv -----
`timescale 1ns / 1ps
// PCI VPD field extractor.
// req channel: one item per begin (tuser 0, image length) or image byte
// (tuser 1). rsp channel: value bytes, field-complete items carrying the
// trimmed length, and one parse-finished item with the reason; tlast marks
// the final rsp item caused by a req item.
// Path: req register -> parser (state + next-state logic) -> 3-slot result
// buffer -> rsp port. A req item is held in the req register, and its rsp
// items are registered into the result buffer, which drives the rsp port.
// Throughput: one req item per cycle while each item yields at most one
// rsp item and rsp_tready is high. An item that yields k rsp items
// (k up to 3) holds the parser until the buffer is down to its last item,
// as the single rsp port drains the buffer one item per cycle at most.
// Reset (synchronous, active high) empties the req register and the result
// buffer and returns the parser to idle; bytes are ignored until a begin.
// When rsp_tready is low, results hold in the buffer, the parser stalls
// and req_tready drops once the req register is occupied.
module pci_vpd_field_extractor
   import vpd_pkg::*;
#(
   parameter int unsigned MAX_IMAGE_BYTES = VPD_MAX_IMAGE_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // image_length[15:0], data_byte[23:16]
   input  logic        req_tuser,    // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // field_id[1:0], value_byte[9:2],
                                     // trimmed_length[25:10],
                                     // finish_status[27:26], zero[31:28]
   output logic [1:0]  rsp_tuser,    // kind
   output logic        rsp_tlast
);

   logic         in_valid_ff, in_valid_in;
   logic         in_op_ff, in_op_in;
   logic [15:0]  in_len_ff, in_len_in;
   logic [7:0]   in_byte_ff, in_byte_in;
   logic         accept;
   logic         process;
   logic         can_load;
   step_out_type step_out;
   rsp_item_type head;

   // the req register advances whenever the parser takes its item
   assign process    = in_valid_ff & can_load;
   assign req_tready = ~in_valid_ff | can_load;
   assign accept     = req_tvalid & req_tready;

   assign in_valid_in = accept | (in_valid_ff & ~process);
   assign in_op_in    = accept ? req_tuser         : in_op_ff;
   assign in_len_in   = accept ? req_tdata[15:0]   : in_len_ff;
   assign in_byte_in  = accept ? req_tdata[23:16]  : in_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_op_ff   <= in_op_in;
      in_len_ff  <= in_len_in;
      in_byte_ff <= in_byte_in;
   end

   vpd_parse #(
      .MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (process),
      .opcode       (in_op_ff),
      .image_length (in_len_ff),
      .data_byte    (in_byte_ff),
      .step_out     (step_out)
   );

   vpd_rbuf u_rbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (process),
      .load_data (step_out),
      .can_load  (can_load),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = {4'd0, head.finish_status, head.trimmed_length,
                       head.value_byte, head.field_id};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
